// ===== design/gte_pkg.sv =====
// Shared types and constants for the GHASH tag engine.
package gte_pkg;

	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned CNT_W   = 5;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_ABSORB = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_index_t;

	// Request after decode: the value folded into the accumulator and the tag mask.
	typedef struct packed {
		action_t            act;
		logic [BLOCK_W-1:0] operand;
		logic [BLOCK_W-1:0] mask;
	} item_t;

endpackage

// ===== design/ghash_tag_engine.sv =====
// GHASH tag engine top level: key registers, request stage, accumulator and result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  request  | req_valid / req_stall      | action, block_*, valid_bytes, *_bytes
//  result   | res_valid / res_stall      | value_high, value_low, is_tag
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One request per cycle while req_stall is low. A request is held in the request stage,
// then its result is registered in the result register. The combinational GF(2^128)
// multiply sits in the accumulator feedback loop. Reset clears the key registers, the
// accumulator and both valid flags. A stalled result holds the request stage, which
// then stalls the request side.
module ghash_tag_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gte_pkg::HALF_W-1:0]  cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  action,
	input  logic [gte_pkg::HALF_W-1:0]  block_high,
	input  logic [gte_pkg::HALF_W-1:0]  block_low,
	input  logic [gte_pkg::CNT_W-1:0]   valid_bytes,
	input  logic [gte_pkg::LEN_W-1:0]   aad_bytes,
	input  logic [gte_pkg::LEN_W-1:0]   text_bytes,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [gte_pkg::HALF_W-1:0]  value_high,
	output logic [gte_pkg::HALF_W-1:0]  value_low,
	output logic                        is_tag
);
	import gte_pkg::*;

	logic [HALF_W-1:0]  key_high_q;
	logic [HALF_W-1:0]  key_low_q;
	logic [BLOCK_W-1:0] acc_q;
	item_t              item;
	item_t              item_s1;
	logic               valid_s1;
	logic               advance;
	logic               load;
	logic [BLOCK_W-1:0] mul_in;
	logic [BLOCK_W-1:0] mul_out;
	logic [BLOCK_W-1:0] acc_next;
	logic [BLOCK_W-1:0] res_next;
	logic               res_valid_q;
	logic [BLOCK_W-1:0] res_value_q;
	logic               is_tag_q;

	gte_operand u_operand (
		.action      (action),
		.block_high  (block_high),
		.block_low   (block_low),
		.valid_bytes (valid_bytes),
		.aad_bytes   (aad_bytes),
		.text_bytes  (text_bytes),
		.item        (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default:      key_high_q <= key_high_q;
			endcase
		end
	end

	assign advance   = !res_valid_q || !res_stall;
	assign req_stall = valid_s1 && !advance;
	assign load      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	assign mul_in = acc_q ^ item_s1.operand;

	gte_gfmul u_gfmul (
		.x (mul_in),
		.h ({key_high_q, key_low_q}),
		.z (mul_out)
	);

	always_comb begin
		unique case (item_s1.act)
			ACT_CLEAR: begin
				acc_next = '0;
				res_next = '0;
			end
			ACT_ABSORB: begin
				acc_next = mul_out;
				res_next = mul_out;
			end
			ACT_FINISH: begin
				acc_next = mul_out;
				res_next = mul_out ^ item_s1.mask;
			end
			ACT_NOP: begin
				acc_next = acc_q;
				res_next = acc_q;
			end
			default: begin
				acc_next = acc_q;
				res_next = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1 && advance) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_value_q <= res_next;
			is_tag_q    <= (item_s1.act == ACT_FINISH);
		end
	end

	assign res_valid  = res_valid_q;
	assign value_high = res_value_q[BLOCK_W-1:HALF_W];
	assign value_low  = res_value_q[HALF_W-1:0];
	assign is_tag     = is_tag_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && res_valid_q)
		else $error("request stalled with no pending request");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && item_s1.act == ACT_CLEAR
		|=> acc_q == '0 && res_valid && value_high == '0 && value_low == '0 && !is_tag)
		else $error("clear did not zero accumulator and result");

	a_finish_tags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && item_s1.act == ACT_FINISH |=> res_valid && is_tag)
		else $error("finish did not produce a tag");

	a_acc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(acc_q))
		else $error("accumulator changed without a request");

endmodule

// ===== design/gte_operand.sv =====
// Request decode: byte masking of data blocks and construction of the length block.
module gte_operand (
	input  logic [1:0]                 action,
	input  logic [gte_pkg::HALF_W-1:0] block_high,
	input  logic [gte_pkg::HALF_W-1:0] block_low,
	input  logic [gte_pkg::CNT_W-1:0]  valid_bytes,
	input  logic [gte_pkg::LEN_W-1:0]  aad_bytes,
	input  logic [gte_pkg::LEN_W-1:0]  text_bytes,
	output gte_pkg::item_t             item
);
	import gte_pkg::*;

	logic [CNT_W-1:0]   nbytes;
	logic [7:0]         shamt;
	logic [BLOCK_W-1:0] keep;
	logic [BLOCK_W-1:0] blk;
	logic [BLOCK_W-1:0] len_blk;
	action_t            act;

	always_comb begin
		nbytes = (valid_bytes > CNT_W'(16)) ? CNT_W'(16) : valid_bytes;
		shamt  = {nbytes, 3'b000};
		// top nbytes bytes kept; shift by 128 yields zero so sixteen keeps all
		keep    = ~({BLOCK_W{1'b1}} >> shamt);
		blk     = {block_high, block_low};
		len_blk = {29'd0, aad_bytes, 3'b000, 29'd0, text_bytes, 3'b000};
		act     = action_t'(action);
	end

	always_comb begin
		item.act  = act;
		item.mask = blk;
		unique case (act)
			ACT_ABSORB: item.operand = blk & keep;
			ACT_FINISH: item.operand = len_blk;
			ACT_CLEAR,
			ACT_NOP:    item.operand = '0;
			default:    item.operand = '0;
		endcase
	end

endmodule

// ===== design/gte_gfmul.sv =====
// GF(2^128) multiply in GCM bit order: carry-less product and reduction.
module gte_gfmul (
	input  logic [gte_pkg::BLOCK_W-1:0] x,
	input  logic [gte_pkg::BLOCK_W-1:0] h,
	output logic [gte_pkg::BLOCK_W-1:0] z
);
	import gte_pkg::*;

	localparam int unsigned PROD_W = 2 * BLOCK_W - 1;

	// GCM bit 0 (MSB) is the x^0 coefficient
	function automatic logic [BLOCK_W-1:0] bitrev(input logic [BLOCK_W-1:0] v);
		logic [BLOCK_W-1:0] r;
		for (int k = 0; k < BLOCK_W; k++) begin
			r[k] = v[BLOCK_W-1-k];
		end
		return r;
	endfunction

	logic [BLOCK_W-1:0] a;
	logic [BLOCK_W-1:0] b;
	logic [PROD_W-1:0]  pp [BLOCK_W];
	logic [PROD_W-1:0]  prod;
	logic [BLOCK_W-2:0] hi;
	logic [BLOCK_W+5:0] t;
	logic [5:0]         u;
	logic [BLOCK_W-1:0] u_ext;
	logic [BLOCK_W-1:0] r;

	assign a = bitrev(x);
	assign b = bitrev(h);

	for (genvar i = 0; i < BLOCK_W; i++) begin : g_row
		assign pp[i] = ({{(BLOCK_W-1){1'b0}}, a} << i) & {PROD_W{b[i]}};
	end

	always_comb begin
		prod = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			prod = prod ^ pp[i];
		end
	end

	// x^128 = x^7 + x^2 + x + 1, folded twice
	always_comb begin
		hi    = prod[PROD_W-1:BLOCK_W];
		t     = {7'd0, hi} ^ {6'd0, hi, 1'b0} ^ {5'd0, hi, 2'b00} ^ {hi, 7'd0};
		u     = t[BLOCK_W+5:BLOCK_W];
		u_ext = {{(BLOCK_W-6){1'b0}}, u};
		r     = prod[BLOCK_W-1:0] ^ t[BLOCK_W-1:0]
		      ^ u_ext ^ (u_ext << 1) ^ (u_ext << 2) ^ (u_ext << 7);
	end

	assign z = bitrev(r);

endmodule
